@@ rtl/first_fit_heap_allocator_defines.svh @@
// Assertion macros shared by the allocator RTL
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FFHA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FFHA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ffha_pkg.sv @@
// Shared constants, codes and helpers for the first-fit heap allocator
`default_nettype none

package ffha_pkg;

	localparam int HEAP_WORDS_DEF = 4096;
	localparam int ALIGN_BYTES    = 8;
	localparam int ALIGN_SHIFT    = 3;
	localparam int REQ_W          = 15;
	localparam int OFS_W          = 15;
	localparam int NEED_W         = REQ_W + 1 - ALIGN_SHIFT;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic ST_DONE    = 1'b0;
	localparam logic ST_NOSPACE = 1'b1;

	// Words needed for a request: payload plus one header word, rounded up
	function automatic logic [NEED_W-1:0] need_words(input logic [REQ_W-1:0] req);
		logic [REQ_W:0] sum;
		sum = {1'b0, req} + (REQ_W+1)'(2 * ALIGN_BYTES - 1);
		return sum[REQ_W:ALIGN_SHIFT];
	endfunction

endpackage

`default_nettype wire

@@ rtl/ffha_req_if.sv @@
// Request channel: allocate or free word with valid/ready handshake
`default_nettype none

interface ffha_req_if import ffha_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             action;
	logic [REQ_W-1:0] request_bytes;
	logic [OFS_W-1:0] payload_offset;

	modport source (output valid, action, request_bytes, payload_offset, input ready);
	modport sink   (input valid, action, request_bytes, payload_offset, output ready);
endinterface

`default_nettype wire

@@ rtl/ffha_rsp_if.sv @@
// Response channel: granted offset and status with valid/ready handshake
`default_nettype none

interface ffha_rsp_if import ffha_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OFS_W-1:0] granted_offset;
	logic             status;

	modport source (output valid, granted_offset, status, input ready);
	modport sink   (input valid, granted_offset, status, output ready);
endinterface

`default_nettype wire

@@ rtl/first_fit_heap_allocator.sv @@
// First-fit heap allocator top level: header memory and walk sequencer
//
// Word-addressed first-fit allocator. Chunk headers (size in words and a used bit)
// live in one synchronous memory of HEAP_WORDS entries with registered read data.
// A free reads the chunk header and writes it back with the used bit clear, or goes
// straight to its result when it is ignored. An allocate reads the chunk headers in
// turn from the bottom, reads the free successor of a chunk that is too small for a
// merge, writes the merged header back when it still falls short, and writes a split
// remainder as a free chunk; the length of the chunk chain below the heap top sets
// how long it takes. Requests are taken one at a time; the response sits in an
// output register, so the next request is accepted while an earlier response waits,
// and it holds in its last cycle until that register is free. The header memory
// needs no clearing after reset.
`default_nettype none

`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int HEAP_WORDS = HEAP_WORDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ffha_req_if.sink   req,
	ffha_rsp_if.source rsp
);

	localparam int AW = $clog2(HEAP_WORDS);
	localparam int SW = $clog2(HEAP_WORDS + 1);
	localparam int HW = SW + 1;
	localparam int CW = (SW > NEED_W) ? SW : NEED_W;
	localparam int EW = CW + 1;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_FREE_RD  = 4'd1;
	localparam logic [3:0] S_WALK_RD  = 4'd2;
	localparam logic [3:0] S_MERGE_RD = 4'd3;
	localparam logic [3:0] S_MERGE_WR = 4'd4;
	localparam logic [3:0] S_TAKE     = 4'd5;
	localparam logic [3:0] S_SPLIT    = 4'd6;
	localparam logic [3:0] S_GROW     = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [HW-1:0] hdr_mem [HEAP_WORDS];
	logic [HW-1:0] rdata_q;

	logic [3:0]        state_q, state_d;
	logic [NEED_W-1:0] need_q, need_d;
	logic [AW-1:0]     at_q, at_d;
	logic [SW-1:0]     sz_q, sz_d;
	logic [SW-1:0]     top_q, top_d;
	logic [OFS_W-1:0]  grant_q, grant_d;
	logic              status_q, status_d;
	logic              res_valid_q;
	logic [OFS_W-1:0]  res_grant_q;
	logic              res_status_q;

	logic          we;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [HW-1:0] wr_data;
	logic          accept, res_load;

	function automatic logic [OFS_W-1:0] grant_of(input logic [AW-1:0] start);
		logic [EW+ALIGN_SHIFT-1:0] g;
		g = {EW'(start) + EW'(1), ALIGN_SHIFT'(0)};
		return g[OFS_W-1:0];
	endfunction

	assign req.ready          = (state_q == S_IDLE);
	assign accept             = req.valid && req.ready;
	assign rsp.valid          = res_valid_q;
	assign rsp.granted_offset = res_grant_q;
	assign rsp.status         = res_status_q;

	// Header memory: one write port, one read port, read data registered.
	// Sequencing never uses a read of an entry in the cycle it is written.
	always_ff @(posedge clk) begin
		if (we)
			hdr_mem[wr_addr] <= wr_data;
		rdata_q <= hdr_mem[rd_addr];
	end

	always_comb begin
		logic [SW-1:0]             h_sz;
		logic                      h_used;
		logic [EW-1:0]             nxt, msum;
		logic [OFS_W-ALIGN_SHIFT-1:0] fw;

		h_sz   = rdata_q[HW-1:1];
		h_used = rdata_q[0];
		nxt    = EW'(at_q) + EW'(h_sz);
		msum   = EW'(sz_q) + EW'(h_sz);
		fw     = req.payload_offset[OFS_W-1:ALIGN_SHIFT] - (OFS_W-ALIGN_SHIFT)'(1);

		state_d  = state_q;
		need_d   = need_q;
		at_d     = at_q;
		sz_d     = sz_q;
		top_d    = top_q;
		grant_d  = grant_q;
		status_d = status_q;
		we       = 1'b0;
		wr_addr  = at_q;
		wr_data  = '0;
		rd_addr  = at_q;
		res_load = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					grant_d  = '0;
					status_d = ST_DONE;
					if (req.action == ACT_FREE) begin
						if (req.payload_offset[OFS_W-1:ALIGN_SHIFT] != '0 &&
						    EW'(fw) < EW'(top_q)) begin
							at_d    = AW'(fw);
							rd_addr = AW'(fw);
							state_d = S_FREE_RD;
						end else begin
							state_d = S_DONE;
						end
					end else begin
						need_d  = need_words(req.request_bytes);
						at_d    = '0;
						rd_addr = '0;
						state_d = (top_q != '0) ? S_WALK_RD : S_GROW;
					end
				end
			end
			S_FREE_RD: begin
				we      = 1'b1;
				wr_addr = at_q;
				wr_data = {rdata_q[HW-1:1], 1'b0};
				state_d = S_DONE;
			end
			S_WALK_RD: begin
				priority if (h_sz == '0) begin
					state_d = S_GROW;
				end else if (!h_used && CW'(h_sz) >= CW'(need_q)) begin
					sz_d    = h_sz;
					state_d = S_TAKE;
				end else if (!h_used && nxt < EW'(top_q)) begin
					// too small: look at the successor for a merge
					sz_d    = h_sz;
					rd_addr = AW'(nxt);
					state_d = S_MERGE_RD;
				end else if (nxt < EW'(top_q)) begin
					at_d    = AW'(nxt);
					rd_addr = AW'(nxt);
				end else begin
					state_d = S_GROW;
				end
			end
			S_MERGE_RD: begin
				if (!h_used) begin
					// absorb the successor and drop its header
					sz_d    = SW'(msum);
					we      = 1'b1;
					wr_addr = AW'(EW'(at_q) + EW'(sz_q));
					wr_data = '0;
					state_d = (msum >= EW'(need_q)) ? S_TAKE : S_MERGE_WR;
				end else begin
					at_d    = AW'(EW'(at_q) + EW'(sz_q));
					rd_addr = AW'(EW'(at_q) + EW'(sz_q));
					state_d = S_WALK_RD;
				end
			end
			S_MERGE_WR: begin
				we      = 1'b1;
				wr_addr = at_q;
				wr_data = {sz_q, 1'b0};
				if (EW'(at_q) + EW'(sz_q) < EW'(top_q)) begin
					at_d    = AW'(EW'(at_q) + EW'(sz_q));
					rd_addr = AW'(EW'(at_q) + EW'(sz_q));
					state_d = S_WALK_RD;
				end else begin
					state_d = S_GROW;
				end
			end
			S_TAKE: begin
				we      = 1'b1;
				wr_addr = at_q;
				wr_data = {SW'(need_q), 1'b1};
				grant_d = grant_of(at_q);
				state_d = (CW'(sz_q) > CW'(need_q)) ? S_SPLIT : S_DONE;
			end
			S_SPLIT: begin
				// leave the remainder as a free chunk
				we      = 1'b1;
				wr_addr = AW'(EW'(at_q) + EW'(need_q));
				wr_data = {SW'(CW'(sz_q) - CW'(need_q)), 1'b0};
				state_d = S_DONE;
			end
			S_GROW: begin
				if (EW'(need_q) <= EW'(HEAP_WORDS) - EW'(top_q)) begin
					we      = 1'b1;
					wr_addr = AW'(top_q);
					wr_data = {SW'(need_q), 1'b1};
					grant_d = grant_of(AW'(top_q));
					top_d   = SW'(EW'(top_q) + EW'(need_q));
				end else begin
					grant_d  = '0;
					status_d = ST_NOSPACE;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (!res_valid_q || rsp.ready) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			if (res_load)
				res_valid_q <= 1'b1;
			else if (rsp.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		need_q   <= need_d;
		at_q     <= at_d;
		sz_q     <= sz_d;
		grant_q  <= grant_d;
		status_q <= status_d;
		if (res_load) begin
			res_grant_q  <= grant_q;
			res_status_q <= status_q;
		end
	end

	`FFHA_ASSERT_IMP(a_top_bound, 1'b1, EW'(top_q) <= EW'(HEAP_WORDS), "heap top beyond heap")
	`FFHA_ASSERT_NXT(a_top_grow_only, state_q != S_GROW, $stable(top_q), "heap top moved outside grow")
	`FFHA_ASSERT_IMP(a_refuse_zero, rsp.valid && rsp.status == ST_NOSPACE, rsp.granted_offset == '0, "refused word carries an offset")
	`FFHA_ASSERT_NXT(a_accept_busy, accept, state_q != S_IDLE, "accepted word left sequencer idle")

endmodule

`default_nettype wire

@@ tb/tb_first_fit_heap_allocator.sv @@
`timescale 1ns / 100ps
// Testbench for the first-fit heap allocator: shadow heap, directed and random traffic

module tb_first_fit_heap_allocator;
	import ffha_pkg::*;

	localparam int WORDS       = HEAP_WORDS_DEF;
	localparam int IDLE_LIMIT  = 50000;
	localparam int HOLD_LEN    = 400;
	localparam int PHASE_ITEMS = 510;
	localparam int SETTLE      = 100;

	typedef struct packed {
		logic [OFS_W-1:0] ofs;
		logic             st;
	} grant_t;

	// Shadow copy of the header store and heap top, plus the grants still owed
	class heap_shadow;
		logic [13:0] hdr [WORDS];
		bit          written [WORDS];
		int          top;
		grant_t      grants_due [$];
		int          errors, checked, allocs, refusals, frees, merges, splits;

		function grant_t note_word(logic act, logic [REQ_W-1:0] rb, logic [OFS_W-1:0] po);
			grant_t g;
			int     need, at, sz, nxt, w;
			bit     done;
			g.ofs = '0;
			g.st  = ST_DONE;
			if (act == ACT_ALLOC) begin
				allocs++;
				need = (int'(rb) + 2 * ALIGN_BYTES - 1) / ALIGN_BYTES;
				at   = 0;
				done = 1'b0;
				while (!done && at < top) begin
					sz = int'(hdr[at][13:1]);
					if (sz == 0) begin
						at = top;
					end else begin
						if (!hdr[at][0]) begin
							nxt = at + sz;
							// absorb a free successor only when this chunk is short
							if (sz < need && nxt < top && !hdr[nxt][0]) begin
								sz += int'(hdr[nxt][13:1]);
								hdr[at]      = 14'(sz << 1);
								hdr[nxt]     = '0;
								written[nxt] = 1'b1;
								merges++;
							end
							if (sz >= need) begin
								if (sz > need) begin
									hdr[at + need]     = 14'((sz - need) << 1);
									written[at + need] = 1'b1;
									splits++;
								end
								hdr[at] = 14'((need << 1) | 1);
								g.ofs   = OFS_W'((at + 1) * ALIGN_BYTES);
								done    = 1'b1;
							end
						end
						if (!done)
							at += sz;
					end
				end
				if (!done) begin
					if (need <= WORDS - top) begin
						hdr[top]     = 14'((need << 1) | 1);
						written[top] = 1'b1;
						g.ofs        = OFS_W'((top + 1) * ALIGN_BYTES);
						top         += need;
					end else begin
						g.st = ST_NOSPACE;
						refusals++;
					end
				end
			end else if (po >= ALIGN_BYTES) begin
				w = (int'(po) - ALIGN_BYTES) / ALIGN_BYTES;
				if (w < top) begin
					hdr[w][0] = 1'b0;
					frees++;
				end
			end
			grants_due.push_back(g);
			return g;
		endfunction

		function void check_result(logic [OFS_W-1:0] ofs, logic st);
			grant_t want;
			if (grants_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word, offset %0d status %0d", $time, ofs, st);
				return;
			end
			want = grants_due.pop_front();
			checked++;
			if (ofs !== want.ofs) begin
				errors++;
				$display("%0t: granted_offset expected %0d actual %0d", $time, want.ofs, ofs);
			end
			if (st !== want.st) begin
				errors++;
				$display("%0t: status expected %0d actual %0d", $time, want.st, st);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ffha_req_if req_if ();
	ffha_rsp_if rsp_if ();

	first_fit_heap_allocator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	heap_shadow       shadow = new();
	logic [OFS_W-1:0] live [$];
	int               src_idle_pct;
	int               rsp_idle_pct;
	int               rsp_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, or a long hold when one is requested
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold > 0) begin
				rsp_hold--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			shadow.check_result(rsp_if.granted_offset, rsp_if.status);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_word(input logic act, input logic [REQ_W-1:0] rb,
			input logic [OFS_W-1:0] po);
		grant_t g;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid          <= 1'b1;
		req_if.action         <= act;
		req_if.request_bytes  <= rb;
		req_if.payload_offset <= po;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		g = shadow.note_word(act, rb, po);
		if (act == ACT_ALLOC && g.st == ST_DONE && g.ofs != '0)
			live.push_back(g.ofs);
	endtask

	// Drop valid and hold until every owed grant has come back
	task automatic drain();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (shadow.grants_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic             act;
		logic [REQ_W-1:0] rb;
		logic [OFS_W-1:0] po;
		logic [OFS_W-1:0] last_freed;
		int               r, s, idx, n, tries;

		arst_n                = 1'b0;
		req_if.valid          = 1'b0;
		req_if.action         = ACT_ALLOC;
		req_if.request_bytes  = '0;
		req_if.payload_offset = '0;
		rsp_hold              = 0;
		src_idle_pct          = 6;
		rsp_idle_pct          = 77;
		last_freed            = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// frees on an empty heap and below the first payload are ignored
		send_word(ACT_FREE, REQ_W'($urandom), 15'd32767);
		send_word(ACT_FREE, REQ_W'($urandom), 15'd0);
		send_word(ACT_ALLOC, 15'd0, OFS_W'($urandom));
		send_word(ACT_FREE, REQ_W'($urandom), 15'd16);
		send_word(ACT_ALLOC, 15'd32767, OFS_W'($urandom));
		// fill to one word short of the end, then take the last word
		send_word(ACT_ALLOC, 15'd32744, OFS_W'($urandom));
		send_word(ACT_ALLOC, 15'd0, OFS_W'($urandom));
		send_word(ACT_ALLOC, 15'd0, OFS_W'($urandom));
		send_word(ACT_FREE, REQ_W'($urandom), 15'd16);
		send_word(ACT_FREE, REQ_W'($urandom), 15'd19);
		// split the big free chunk, then merge two freed neighbours into an exact fit
		send_word(ACT_ALLOC, 15'd8, OFS_W'($urandom));
		send_word(ACT_ALLOC, 15'd1, OFS_W'($urandom));
		send_word(ACT_ALLOC, 15'd7, OFS_W'($urandom));
		send_word(ACT_FREE, REQ_W'($urandom), 15'd16);
		send_word(ACT_FREE, REQ_W'($urandom), 15'd32);
		send_word(ACT_ALLOC, 15'd24, OFS_W'($urandom));
		send_word(ACT_FREE, REQ_W'($urandom), 15'd32);
		send_word(ACT_FREE, REQ_W'($urandom), 15'd48);
		send_word(ACT_ALLOC, 15'd16, OFS_W'($urandom));
		// merge that still falls short, so the walk moves on
		send_word(ACT_ALLOC, 15'd0, OFS_W'($urandom));
		send_word(ACT_ALLOC, 15'd0, OFS_W'($urandom));
		send_word(ACT_FREE, REQ_W'($urandom), 15'd72);
		send_word(ACT_FREE, REQ_W'($urandom), 15'd80);
		send_word(ACT_ALLOC, 15'd16, OFS_W'($urandom));
		send_word(ACT_FREE, REQ_W'($urandom), 15'd16);
		send_word(ACT_ALLOC, 15'd24, OFS_W'($urandom));
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 77 : 0;
			rsp_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 6 : 0;
			if (ph == 2)
				rsp_hold = HOLD_LEN;
			n = 0;
			while (n < PHASE_ITEMS) begin
				r  = $urandom_range(0, 99);
				rb = REQ_W'($urandom);
				po = OFS_W'($urandom);
				if (r < 50 || live.size() == 0) begin
					act = ACT_ALLOC;
					s = $urandom_range(0, 99);
					if (s < 60)
						rb = REQ_W'($urandom_range(0, 63));
					else if (s < 87)
						rb = REQ_W'($urandom_range(64, 511));
					else if (s < 95)
						rb = REQ_W'($urandom_range(512, 4095));
					else if (s < 99)
						rb = REQ_W'($urandom_range(4096, 16383));
					else
						rb = REQ_W'($urandom_range(16384, 32767));
				end else if (r < 88) begin
					act = ACT_FREE;
					idx = $urandom_range(0, live.size() - 1);
					po  = live[idx];
					live.delete(idx);
					if ($urandom_range(0, 3) == 0)
						po[2:0] = 3'($urandom_range(0, 7));
					last_freed = po;
				end else if (r < 93) begin
					act = ACT_FREE;
					po  = last_freed;
				end else begin
					// stray free; steer clear of words never written
					act   = ACT_FREE;
					tries = 0;
					po    = OFS_W'($urandom_range(0, 32767));
					while (po >= ALIGN_BYTES
							&& (po - ALIGN_BYTES) / ALIGN_BYTES < shadow.top
							&& !shadow.written[(po - ALIGN_BYTES) / ALIGN_BYTES]) begin
						tries++;
						if (tries < 8)
							po = OFS_W'($urandom_range(0, 32767));
						else
							po = OFS_W'($urandom_range(0, ALIGN_BYTES - 1));
					end
				end
				send_word(act, rb, po);
				if (act == ACT_ALLOC || po >= ALIGN_BYTES)
					n++;
			end
			drain();
		end

		repeat (SETTLE) @(posedge clk);
		$display("Run: %0d allocates (%0d refused), %0d effective frees, %0d merges, %0d splits.",
			shadow.allocs, shadow.refusals, shadow.frees, shadow.merges, shadow.splits);
		$display("Checked %0d result words across three stall mixes and a long output hold.",
			shadow.checked);
		if (shadow.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ first_fit_heap_allocator.f @@
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_req_if.sv
rtl/ffha_rsp_if.sv
rtl/first_fit_heap_allocator.sv
tb/tb_first_fit_heap_allocator.sv
